// ----- rtl/ippd_pkg.sv -----
// Package for the IPv4 protocol dispatch table: sizes, codes and transaction types.
// Depends on nothing; every module of the block imports it.
package ippd_pkg;

    localparam int TABLE_ENTRIES = 64;
    localparam int ADDR_W        = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);

    localparam int QUEUE_DEPTH   = 2;
    localparam int QPTR_W        = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);

    localparam int CFG_IDX_W     = 2;

    localparam logic [CFG_IDX_W-1:0] REG_OWN_IP   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BCAST_IP = 2'd1;

    localparam logic [15:0] HDR_BYTES = 16'd20;
    localparam logic [31:0] BCAST_RESET = 32'hFFFF_FFFF;

    localparam logic MODE_REGISTER = 1'b0;
    localparam logic MODE_CLASSIFY = 1'b1;

    localparam logic [2:0] ST_NEW        = 3'd0;
    localparam logic [2:0] ST_OVERRIDE   = 3'd1;
    localparam logic [2:0] ST_FULL       = 3'd2;
    localparam logic [2:0] ST_DELIVERED  = 3'd3;
    localparam logic [2:0] ST_WRONG_IP   = 3'd4;
    localparam logic [2:0] ST_NO_HANDLER = 3'd5;

    typedef struct packed {
        logic        mode;
        logic [7:0]  protocol;
        logic [7:0]  handler_id;
        logic [31:0] dst_ip;
        logic [31:0] src_ip;
        logic [15:0] total_length;
    } cmd_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [7:0]  out_handler;
        logic [15:0] payload_length;
        logic [31:0] sender_ip;
    } result_t;

    typedef struct packed {
        logic        mode;
        logic        addr_ok;
        logic [7:0]  protocol;
        logic [7:0]  handler_id;
        logic [31:0] src_ip;
        logic [15:0] payload_length;
    } job_t;

    typedef struct packed {
        logic empty;
        logic full;
    } queue_status_t;

    typedef struct packed {
        logic [7:0] protocol;
        logic [7:0] handler;
    } entry_t;

endpackage

// ----- rtl/ippd_front.sv -----
// Front end: address registers, command acceptance and header classification.
// Depends on ippd_pkg; feeds classified jobs into ippd_queue.
module ippd_front (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  ippd_pkg::cmd_t                  cmd,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [ippd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [31:0]                     cfg_data,
    input  ippd_pkg::queue_status_t         q_status,
    output logic                            push,
    output ippd_pkg::job_t                  job
);
    import ippd_pkg::*;

    logic [31:0] own_ip_reg;
    logic [31:0] bcast_ip_reg;

    assign cfg_ready = 1'b1;
    assign busy      = q_status.full;
    assign push      = start && !q_status.full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_ip_reg   <= '0;
            bcast_ip_reg <= BCAST_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_OWN_IP:   own_ip_reg   <= cfg_data;
                REG_BCAST_IP: bcast_ip_reg <= cfg_data;
                default:      ;
            endcase
        end
    end

    always_comb
    begin
        job.mode       = cmd.mode;
        job.addr_ok    = (cmd.dst_ip == own_ip_reg) || (cmd.dst_ip == bcast_ip_reg);
        job.protocol   = cmd.protocol;
        job.handler_id = cmd.handler_id;
        job.src_ip     = cmd.src_ip;
        if (cmd.total_length >= HDR_BYTES)
            job.payload_length = cmd.total_length - HDR_BYTES;
        else
            job.payload_length = '0;
    end

endmodule

// ----- rtl/ippd_queue.sv -----
// Short job queue between the front end and the table sequencer.
// Depends on ippd_pkg for the job type and depth.
module ippd_queue (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    input  ippd_pkg::job_t          push_data,
    input  logic                    pop,
    output ippd_pkg::job_t          head,
    output ippd_pkg::queue_status_t q_status
);
    import ippd_pkg::*;

    job_t              slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] cnt_reg;
    logic [QCNT_W-1:0] cnt_next;

    assign head           = slot_reg[rd_ptr_reg];
    assign q_status.empty = (cnt_reg == '0);
    assign q_status.full  = (cnt_reg == QCNT_W'(QUEUE_DEPTH));

    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !pop)
            cnt_next = cnt_reg + 1'b1;
        else if (pop && !push)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_data;
    end

endmodule

// ----- rtl/ippd_back.sv -----
// Back end: table memory, fill count and the entry-by-entry scan sequencer.
// Depends on ippd_pkg; takes jobs from ippd_queue and drives the result strobe.
module ippd_back (
    input  logic                    clk,
    input  logic                    rst_n,
    input  ippd_pkg::job_t          head,
    input  ippd_pkg::queue_status_t q_status,
    output logic                    pop,
    output logic                    result_valid,
    output ippd_pkg::result_t       result
);
    import ippd_pkg::*;

    localparam logic S_IDLE = 1'b0;
    localparam logic S_SCAN = 1'b1;

    entry_t            table_mem [TABLE_ENTRIES];
    entry_t            rd_data_reg;

    logic              state_reg;
    job_t              cur_reg;
    logic [CNT_W-1:0]  fill_reg;
    logic [CNT_W-1:0]  scan_idx_reg;
    logic [ADDR_W-1:0] cmp_idx_reg;
    logic              cmp_vld_reg;
    logic              done_reg;
    result_t           result_reg;
    result_t           result_next;

    logic              more;
    logic              hit;
    logic              miss;
    logic              issue;
    logic              direct;
    logic              has_room;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;

    assign more     = (scan_idx_reg < fill_reg);
    assign has_room = (fill_reg < CNT_W'(TABLE_ENTRIES));
    assign hit      = (state_reg == S_SCAN) && cmp_vld_reg
                      && (rd_data_reg.protocol == cur_reg.protocol);
    assign miss     = (state_reg == S_SCAN) && !cmp_vld_reg && !more;
    assign issue    = (state_reg == S_SCAN) && more && !hit;
    assign pop      = (state_reg == S_IDLE) && !q_status.empty;
    assign direct   = pop && (head.mode == MODE_CLASSIFY) && !head.addr_ok;
    assign wr_en    = (cur_reg.mode == MODE_REGISTER) && (hit || (miss && has_room));
    assign wr_addr  = hit ? cmp_idx_reg : fill_reg[ADDR_W-1:0];

    always_comb
    begin
        result_next = '0;
        if (direct)
            result_next.status = ST_WRONG_IP;
        else if (hit)
        begin
            if (cur_reg.mode == MODE_REGISTER)
                result_next.status = ST_OVERRIDE;
            else
            begin
                result_next.status         = ST_DELIVERED;
                result_next.out_handler    = rd_data_reg.handler;
                result_next.payload_length = cur_reg.payload_length;
                result_next.sender_ip      = cur_reg.src_ip;
            end
        end
        else if (cur_reg.mode == MODE_REGISTER)
            result_next.status = has_room ? ST_NEW : ST_FULL;
        else
            result_next.status = ST_NO_HANDLER;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            fill_reg     <= '0;
            scan_idx_reg <= '0;
            cmp_vld_reg  <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (direct)
                        done_reg <= 1'b1;
                    else if (pop)
                    begin
                        state_reg    <= S_SCAN;
                        scan_idx_reg <= '0;
                        cmp_vld_reg  <= 1'b0;
                    end
                end
                S_SCAN:
                begin
                    cmp_vld_reg <= issue;
                    if (issue)
                        scan_idx_reg <= scan_idx_reg + 1'b1;
                    if (hit || miss)
                    begin
                        state_reg   <= S_IDLE;
                        cmp_vld_reg <= 1'b0;
                        done_reg    <= 1'b1;
                        if (miss && wr_en)
                            fill_reg <= fill_reg + 1'b1;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
            cur_reg <= head;
        cmp_idx_reg <= scan_idx_reg[ADDR_W-1:0];
        if (direct || hit || miss)
            result_reg <= result_next;
    end

    always_ff @(posedge clk)
    begin
        rd_data_reg <= table_mem[scan_idx_reg[ADDR_W-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            table_mem[wr_addr] <= '{protocol: cur_reg.protocol, handler: cur_reg.handler_id};
    end

    assign result_valid = done_reg;
    assign result       = result_reg;

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= CNT_W'(TABLE_ENTRIES))
        else $error("fill count beyond table size");

    a_fill_only_new: assert property (@(posedge clk) disable iff (!rst_n)
        (fill_reg != $past(fill_reg)) |-> (result_valid && result.status == ST_NEW))
        else $error("fill count moved without a new registration");

    a_delivered_after_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.status == ST_DELIVERED) |-> $past(state_reg == S_SCAN))
        else $error("delivery without a table scan");

    a_no_pop_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> !pop)
        else $error("job taken while a scan is running");

endmodule

// ----- rtl/ip_protocol_dispatch_table_core.sv -----
// Top level of the IPv4 protocol dispatch table.
// Depends on ippd_pkg, ippd_front, ippd_queue and ippd_back.
//
// Command channel: a transaction is taken at a rising edge with start high and
// busy low. mode 0 registers handler_id for protocol; mode 1 classifies a
// received header against own_ip / broadcast_ip and the table.
// Config channel: cfg_valid/cfg_ready with cfg_index (0 own_ip, 1 broadcast_ip,
// other indexes ignored) and cfg_data; cfg_ready is always high.
// Results: one per command, in command order, on result for exactly one cycle
// with result_valid high. The receiver cannot stall, so nothing holds results.
// Timing: a two-entry queue parts the front end from the table sequencer; busy
// is high only while that queue is full. The sequencer reads one table entry a
// cycle and serves one command at a time: it takes the next job from the queue
// only when idle, and a protocol match ends the scan early. A wrong-address
// header skips the scan and is answered straight from the idle state.
// Reset: empties the queue, clears the fill count (table empty at once, no
// clearing pass), own_ip to 0 and broadcast_ip to all ones.
module ip_protocol_dispatch_table_core (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  ippd_pkg::cmd_t                  cmd,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [ippd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [31:0]                     cfg_data,
    output logic                            result_valid,
    output ippd_pkg::result_t               result
);
    import ippd_pkg::*;

    logic          push;
    logic          pop;
    job_t          job;
    job_t          head;
    queue_status_t q_status;

    ippd_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .cmd       (cmd),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_status  (q_status),
        .push      (push),
        .job       (job)
    );

    ippd_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (job),
        .pop       (pop),
        .head      (head),
        .q_status  (q_status)
    );

    ippd_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (head),
        .q_status     (q_status),
        .pop          (pop),
        .result_valid (result_valid),
        .result       (result)
    );

endmodule
